// ===== rtl/tlvrp_pkg.sv =====
// Shared types and constants for the TLV record parser.
`timescale 1ns / 1ps
`default_nettype none

package tlvrp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_TAG     = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DRAIN   = 3'd5
    } t_phase;

    // Result event codes
    localparam logic [2:0] EV_COUNT = 3'd0;
    localparam logic [2:0] EV_TIME  = 3'd1;
    localparam logic [2:0] EV_MASS  = 3'd2;
    localparam logic [2:0] EV_SKIP  = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_MAGIC   = 2'd1;
    localparam logic [1:0] ERR_VERSION = 2'd2;
    localparam logic [1:0] ERR_TRUNC   = 2'd3;

    // Known tags
    localparam logic [15:0] TAG_COUNT = 16'd1;
    localparam logic [15:0] TAG_TIME  = 16'd2;
    localparam logic [15:0] TAG_MASS  = 16'd3;

    // Configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_MIN_VER = 1'b1;

    localparam logic [31:0] MAGIC_RESET   = 32'h5944_424E;
    localparam logic [31:0] MIN_VER_RESET = 32'd1;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [63:0] value;
        logic [1:0]  error_code;
        logic        run_last;
    } t_out;

    // Results produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] num;
        t_out       res0;
        t_out       res1;
    } t_step;

endpackage

`default_nettype wire

// ===== rtl/tlvrp_core.sv =====
// Parser state registers and the per-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

module tlvrp_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_acc,
    input  tlvrp_pkg::t_in      i_in,
    input  wire [31:0]          i_magic,
    input  wire [31:0]          i_min_ver,
    output tlvrp_pkg::t_step    o_step
);
    import tlvrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ucnt, n_ucnt;
    logic [63:0] r_asm, n_asm;
    logic [15:0] r_tag, n_tag;
    logic [31:0] r_remain, n_remain;
    logic        r_taken, n_taken;
    logic [1:0]  r_perr, n_perr;

    logic [63:0] w_asm;
    logic [31:0] w_dec;
    logic        hit0;
    t_out        res_a;
    t_out        res_t;

    // Byte merged into the assembly word at its little-endian slot
    assign w_asm = r_asm | (64'(i_in.data_byte) << {r_ucnt, 3'b000});
    assign w_dec = r_remain - 32'd1;

    // Step logic: next state and results for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_ucnt   = r_ucnt;
        n_asm    = r_asm;
        n_tag    = r_tag;
        n_remain = r_remain;
        n_taken  = r_taken;
        n_perr   = r_perr;
        hit0     = 1'b0;
        res_a    = '0;
        res_t    = '0;

        case (r_phase)
            PH_MAGIC: begin
                if (r_ucnt == 3'd3) begin
                    if (w_asm[31:0] != i_magic) begin
                        n_perr  = ERR_MAGIC;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_VERSION;
                    end
                    n_ucnt = 3'd0;
                    n_asm  = '0;
                end else begin
                    n_asm  = w_asm;
                    n_ucnt = r_ucnt + 3'd1;
                end
            end
            PH_VERSION: begin
                if (r_ucnt == 3'd3) begin
                    if (w_asm[31:0] < i_min_ver) begin
                        n_perr  = ERR_VERSION;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_TAG;
                    end
                    n_ucnt = 3'd0;
                    n_asm  = '0;
                end else begin
                    n_asm  = w_asm;
                    n_ucnt = r_ucnt + 3'd1;
                end
            end
            PH_TAG: begin
                if (r_ucnt >= 3'd1) begin
                    n_tag   = w_asm[15:0];
                    n_phase = PH_LEN;
                    n_ucnt  = 3'd0;
                    n_asm   = '0;
                end else begin
                    n_asm  = w_asm;
                    n_ucnt = r_ucnt + 3'd1;
                end
            end
            PH_LEN: begin
                if (r_ucnt == 3'd3) begin
                    n_remain = w_asm[31:0];
                    n_taken  = 1'b0;
                    if (r_tag != TAG_COUNT && r_tag != TAG_TIME && r_tag != TAG_MASS) begin
                        hit0            = 1'b1;
                        res_a.event_res = EV_SKIP;
                        res_a.value     = 64'(r_tag);
                    end
                    n_phase = (w_asm[31:0] != 32'd0) ? PH_PAYLOAD : PH_TAG;
                    n_ucnt  = 3'd0;
                    n_asm   = '0;
                end else begin
                    n_asm  = w_asm;
                    n_ucnt = r_ucnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (r_tag == TAG_COUNT || r_tag == TAG_TIME) begin
                    // Only the first bytes of the field form the value
                    if (!r_taken) begin
                        if ((r_tag == TAG_COUNT && r_ucnt == 3'd3) ||
                            (r_tag == TAG_TIME && r_ucnt == 3'd7)) begin
                            hit0 = 1'b1;
                            if (r_tag == TAG_COUNT) begin
                                res_a.event_res = EV_COUNT;
                                res_a.value     = {32'd0, w_asm[31:0]};
                            end else begin
                                res_a.event_res = EV_TIME;
                                res_a.value     = w_asm;
                            end
                            n_taken = 1'b1;
                            n_ucnt  = 3'd0;
                            n_asm   = '0;
                        end else begin
                            n_asm  = w_asm;
                            n_ucnt = r_ucnt + 3'd1;
                        end
                    end
                end else if (r_tag == TAG_MASS) begin
                    // One mass word per full 8-byte group
                    if (r_ucnt == 3'd7) begin
                        hit0            = 1'b1;
                        res_a.event_res = EV_MASS;
                        res_a.value     = w_asm;
                        n_ucnt          = 3'd0;
                        n_asm           = '0;
                    end else begin
                        n_asm  = w_asm;
                        n_ucnt = r_ucnt + 3'd1;
                    end
                end
                n_remain = w_dec;
                if (w_dec == 32'd0) begin
                    n_phase = PH_TAG;
                    n_ucnt  = 3'd0;
                    n_asm   = '0;
                end
            end
            default: begin
            end
        endcase

        // Terminal result on the final byte, then start a fresh record
        if (i_in.end_of_record) begin
            if (n_perr != ERR_NONE) begin
                res_t.event_res  = EV_ERROR;
                res_t.error_code = n_perr;
            end else if (n_phase == PH_MAGIC || n_phase == PH_VERSION) begin
                res_t.event_res  = EV_ERROR;
                res_t.error_code = ERR_MAGIC;
            end else if (n_phase == PH_PAYLOAD) begin
                res_t.event_res  = EV_ERROR;
                res_t.error_code = ERR_TRUNC;
            end else begin
                res_t.event_res = EV_DONE;
            end
            res_t.run_last = 1'b1;
            n_phase  = PH_MAGIC;
            n_ucnt   = 3'd0;
            n_asm    = '0;
            n_tag    = '0;
            n_remain = '0;
            n_taken  = 1'b0;
            n_perr   = ERR_NONE;
        end else begin
            res_a.run_last = 1'b1;
        end

        // Pack results in order
        o_step = '0;
        if (hit0) begin
            o_step.res0 = res_a;
            o_step.res1 = res_t;
            o_step.num  = i_in.end_of_record ? 2'd2 : 2'd1;
        end else begin
            o_step.res0 = res_t;
            o_step.num  = i_in.end_of_record ? 2'd1 : 2'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_ucnt   <= 3'd0;
            r_asm    <= '0;
            r_tag    <= '0;
            r_remain <= '0;
            r_taken  <= 1'b0;
            r_perr   <= ERR_NONE;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_ucnt   <= n_ucnt;
            r_asm    <= n_asm;
            r_tag    <= n_tag;
            r_remain <= n_remain;
            r_taken  <= n_taken;
            r_perr   <= n_perr;
        end
    end

    // A record end always returns to a clean magic phase
    a_eor_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_in.end_of_record) |=> (r_phase == PH_MAGIC && r_perr == ERR_NONE))
        else $error("record state not cleared after end of record");

    // Magic, version and length counters never pass the fourth byte
    a_hdr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC || r_phase == PH_VERSION || r_phase == PH_LEN) |-> r_ucnt <= 3'd3)
        else $error("header byte counter out of range");

    // A pending error only exists while draining
    a_perr_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_perr != ERR_NONE) |-> (r_phase == PH_DRAIN))
        else $error("pending error outside drain phase");

endmodule

`default_nettype wire

// ===== rtl/tlv_record_parser_unit.sv =====
// Top level of the TLV record parser: config registers, parser core, result queue.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream TLV record parser. One record byte is taken per request on the input
// channel, and a new byte can be taken every clock cycle. Each byte yields zero, one
// or two result requests (a value or skip event, and the done/error event on the final
// byte). Results enter a 4-entry queue in the same cycle the byte is taken; the input
// is held off while fewer than two queue slots are free, so bytes that yield two
// results are paced by the output side. Results are registered in the queue before they
// reach the output. The user must write the magic word (index 0) and minimum version
// (index 1) through the config port while the block is idle; the block does not check it.
module tlv_record_parser_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [0:0]           i_cfg_idx,
    input  wire [31:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tlvrp_pkg::t_in      i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tlvrp_pkg::t_out     o_out
);
    import tlvrp_pkg::*;

    logic [31:0]    r_magic;
    logic [31:0]    r_min_ver;
    t_out           r_q [QDEPTH];
    t_out           n_q [QDEPTH];
    logic [QCW-1:0] r_count, n_count;
    logic [QCW-1:0] base;
    logic           in_acc;
    logic           pop;
    logic [1:0]     push;
    t_step          step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_min_ver <= MIN_VER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx[0] == CFG_MAGIC)   r_magic   <= i_cfg_data;
            if (i_cfg_idx[0] == CFG_MIN_VER) r_min_ver <= i_cfg_data;
        end
    end

    // Handshakes
    assign o_in_ready  = (r_count <= QCW'(QDEPTH - 2));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign push        = in_acc ? step.num : 2'd0;
    assign o_out       = r_q[0];

    tlvrp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (in_acc),
        .i_in      (i_in),
        .i_magic   (r_magic),
        .i_min_ver (r_min_ver),
        .o_step    (step)
    );

    // Shifting result queue: head at entry 0, new results appended behind the tail
    always_comb begin
        base    = r_count - QCW'(pop);
        n_count = base + QCW'(push);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[(i < QDEPTH - 1) ? i + 1 : i];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push != 2'd0 && base == QCW'(i)) begin
                n_q[i] = step.res0;
            end
            if (push == 2'd2 && base + QCW'(1) == QCW'(i)) begin
                n_q[i] = step.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue overflow");

    // The final byte of a record always leaves a result waiting
    a_eor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.end_of_record) |=> (r_count != '0))
        else $error("no terminal result queued for end of record");

    // A byte taken into an empty queue that yields results shows them next cycle
    a_q_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && in_acc && step.num != 2'd0) |=> o_out_valid)
        else $error("result not presented after byte");

endmodule

`default_nettype wire
